// ===== hdl/wav_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WAV header parser package
// Payload types, tag constants and status codes shared by the parser files.
// ---------------------------------------------------------------------------
package wav_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [7:0]  FMT_F = 8'h66;
  localparam logic [7:0]  FMT_M = 8'h6D;
  localparam logic [7:0]  FMT_T = 8'h74;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ST_NOT_PCM   = 3'd3;
  localparam logic [2:0] ST_BAD_CHAN  = 3'd4;
  localparam logic [2:0] ST_SIZE_MISM = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        riff_size;
    logic [9:0]         metadata_length;
    logic [31:0]        format_chunk_size;
    logic [15:0]        channels;
    logic [31:0]        rate_hz;
    logic [31:0]        bytes_per_sec;
    logic [15:0]        block_align;
    logic [15:0]        sample_bits;
    logic signed [10:0] extra_length;
    logic [31:0]        payload_bytes;
    logic [34:0]        block_count;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [34:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

endpackage

// ===== hdl/wav_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WAV block count divider
// Restoring divider, one quotient bit per cycle; a zero divisor gives zero.
// ---------------------------------------------------------------------------
module wav_div
  import wav_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        busy,
  output logic [34:0] quotient
);

  logic [5:0]  count;
  logic [34:0] dvd;
  logic [17:0] rem;
  logic [16:0] dvs;
  logic [17:0] trial;

  assign trial = {rem[16:0], dvd[34]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy <= (req.divisor != '0);
      count <= 6'd35;
      dvd <= req.dividend;
      dvs <= req.divisor;
      rem <= '0;
      quotient <= '0;
    end else if (busy) begin
      if (!trial[17]) begin
        rem <= trial;
        quotient <= {quotient[33:0], 1'b1};
      end else begin
        rem <= {rem[16:0], dvd[34]};
        quotient <= {quotient[33:0], 1'b0};
      end
      dvd <= {dvd[33:0], 1'b0};
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/wav_header_stream_parser.sv =====
`timescale 1ns / 1ps
// Result path: the result of the last data size byte is registered in div_wait,
// waits there while the 35-step divider runs, then is registered in out_valid.
// Throughput: one byte per cycle while parsing; input stalls during division
// and while a result waits to be taken.
// Reset (rst, synchronous): parser expects the RIFF tag, scan_limit = 300.
// ---------------------------------------------------------------------------
// WAV header stream parser
// Parses a RIFF/WAVE PCM header byte by byte and emits one result item.
// ---------------------------------------------------------------------------
module wav_header_stream_parser
  import wav_pkg::*;
#(
  parameter int ScanReset = 300
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [9:0] cfg_data
);

  typedef enum logic [13:0] {
    P_RIFF = 14'b00000000000001, P_RSIZE = 14'b00000000000010,
    P_WAVE = 14'b00000000000100, P_FMT = 14'b00000000001000,
    P_SKIP = 14'b00000000010000, P_CSIZE = 14'b00000000100000,
    P_FORMAT = 14'b00000001000000, P_CHAN = 14'b00000010000000,
    P_RATE = 14'b00000100000000, P_BRATE = 14'b00001000000000,
    P_ALIGN = 14'b00010000000000, P_BITS = 14'b00100000000000,
    P_DSCAN = 14'b01000000000000, P_DSIZE = 14'b10000000000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [9:0]  scan_limit;
  logic [9:0]  byte_counter, byte_counter_next;
  logic [1:0]  tag_match_count, tag_match_count_next;
  logic [31:0] tag_window, tag_window_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [31:0] riff_size, csize, rate, brate, dsize;
  logic [9:0]  meta;
  logic [15:0] chan, align, bits;
  logic [9:0]  extra;

  // Result pipeline: emit request, then divide, then hold until taken.
  logic        emit, emit_ok;
  logic [2:0]  emit_status;
  logic        div_wait;
  logic [2:0]  pend_status;
  logic        div_busy;
  logic [34:0] quotient;
  div_req_t    dreq;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid | div_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= 10'(ScanReset);
    end else if (cfg_valid) begin
      scan_limit <= cfg_data;
    end
  end

  logic        acc;
  logic [31:0] win_shift, acc_merge;
  logic [9:0]  bc_base, bc_inc, cnt;
  logic [1:0]  tm_base;
  phase_t      ph_base;
  logic [31:0] fa_base, tw_base;
  logic [7:0]  fmt_chr;

  assign acc = in_valid & ~in_stall;

  always_comb begin
    ph_base = in_data.restart ? P_RIFF : phase;
    bc_base = in_data.restart ? 10'd0 : byte_counter;
    tm_base = in_data.restart ? 2'd0 : tag_match_count;
    tw_base = in_data.restart ? 32'd0 : tag_window;
    fa_base = in_data.restart ? 32'd0 : field_accumulator;
    bc_inc = bc_base + 10'd1;
    win_shift = {tw_base[23:0], in_data.data_byte};
    acc_merge = fa_base | (32'(in_data.data_byte) << {bc_base[1:0], 3'b000});
    phase_next = ph_base;
    byte_counter_next = bc_base;
    tag_match_count_next = tm_base;
    tag_window_next = tw_base;
    field_accumulator_next = fa_base;
    emit = 1'b0;
    emit_status = ST_OK;
    cnt = bc_base;
    fmt_chr = FMT_F;
    case (tm_base)
      2'd1: fmt_chr = FMT_M;
      2'd2: fmt_chr = FMT_T;
      default: fmt_chr = FMT_F;
    endcase
    case (ph_base)
      P_RIFF, P_WAVE: begin
        tag_window_next = win_shift;
        byte_counter_next = bc_inc;
        if (bc_inc >= 10'd4) begin
          byte_counter_next = '0;
          tag_window_next = '0;
          if (ph_base == P_RIFF) begin
            if (win_shift != TAG_RIFF) begin
              emit = 1'b1; emit_status = ST_NOT_RIFF;
            end
            phase_next = P_RSIZE;
          end else begin
            if (win_shift != TAG_WAVE) begin
              emit = 1'b1; emit_status = ST_NOT_WAVE;
            end
            phase_next = P_FMT;
            tag_match_count_next = '0;
          end
        end
      end
      P_FMT: begin
        if (bc_base >= scan_limit) begin
          phase_next = P_SKIP;
        end else begin
          cnt = bc_inc;
          if (in_data.data_byte == fmt_chr) begin
            tag_match_count_next = tm_base + 2'd1;
            if (tm_base == 2'd2) phase_next = P_SKIP;
          end else begin
            tag_match_count_next = '0;
          end
        end
        byte_counter_next = cnt;
        if (phase_next == P_SKIP) begin
          byte_counter_next = '0;
          tag_match_count_next = '0;
        end
      end
      P_SKIP: phase_next = P_CSIZE;
      P_DSCAN: begin
        if (tm_base != 2'd0) cnt = bc_inc;
        tag_match_count_next = 2'd1;
        tag_window_next = win_shift;
        byte_counter_next = cnt;
        if (win_shift == TAG_DATA || cnt >= scan_limit) begin
          byte_counter_next = '0;
          tag_match_count_next = '0;
          tag_window_next = '0;
          field_accumulator_next = '0;
          phase_next = P_DSIZE;
        end
      end
      default: begin
        // Little-endian field phases.
        field_accumulator_next = acc_merge;
        byte_counter_next = bc_inc;
        if (((ph_base == P_FORMAT || ph_base == P_CHAN || ph_base == P_ALIGN ||
              ph_base == P_BITS) && bc_inc >= 10'd2) || bc_inc >= 10'd4) begin
          field_accumulator_next = '0;
          byte_counter_next = '0;
          case (ph_base)
            P_RSIZE: phase_next = P_WAVE;
            P_CSIZE: phase_next = P_FORMAT;
            P_FORMAT: begin
              if (acc_merge != 32'd1) begin
                emit = 1'b1; emit_status = ST_NOT_PCM;
              end
              phase_next = P_CHAN;
            end
            P_CHAN: begin
              if (acc_merge != 32'd1 && acc_merge != 32'd2) begin
                emit = 1'b1; emit_status = ST_BAD_CHAN;
              end
              phase_next = P_RATE;
            end
            P_RATE: phase_next = P_BRATE;
            P_BRATE: phase_next = P_ALIGN;
            P_ALIGN: phase_next = P_BITS;
            P_BITS: begin
              phase_next = P_DSCAN;
              tag_window_next = '0;
              tag_match_count_next = '0;
            end
            default: begin
              emit = 1'b1;
              emit_status = ({1'b0, chan} * {1'b0, bits}) == {align[13:0], 3'b000} &&
                            align[15:14] == 2'b00 ? ST_OK : ST_SIZE_MISM;
            end
          endcase
        end
      end
    endcase
    if (emit) begin
      phase_next = P_RIFF;
      byte_counter_next = '0;
      tag_match_count_next = '0;
      tag_window_next = '0;
      field_accumulator_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_RIFF;
      byte_counter <= '0;
      tag_match_count <= '0;
      tag_window <= '0;
      field_accumulator <= '0;
    end else if (acc) begin
      phase <= phase_next;
      byte_counter <= byte_counter_next;
      tag_match_count <= tag_match_count_next;
      tag_window <= tag_window_next;
      field_accumulator <= field_accumulator_next;
    end
  end

  // Captured header fields.
  always_ff @(posedge clk) begin
    if (acc && !emit) begin
      if (ph_base == P_RSIZE && phase_next == P_WAVE) riff_size <= acc_merge;
      if (ph_base == P_FMT && phase_next == P_SKIP) meta <= (cnt > 10'd3) ? cnt - 10'd3 : 10'd0;
      if (ph_base == P_CSIZE && phase_next == P_FORMAT) csize <= acc_merge;
      if (ph_base == P_CHAN && phase_next == P_RATE) chan <= acc_merge[15:0];
      if (ph_base == P_RATE && phase_next == P_BRATE) rate <= acc_merge;
      if (ph_base == P_BRATE && phase_next == P_ALIGN) brate <= acc_merge;
      if (ph_base == P_ALIGN && phase_next == P_BITS) align <= acc_merge[15:0];
      if (ph_base == P_BITS && phase_next == P_DSCAN) bits <= acc_merge[15:0];
      if (ph_base == P_DSCAN && phase_next == P_DSIZE) extra <= cnt;
    end
    if (acc && emit && ph_base == P_DSIZE) dsize <= acc_merge;
  end

  assign emit_ok = acc && emit && emit_status == ST_OK;

  // Channels is 1 or 2, so the product fits in 17 bits.
  assign dreq.start    = emit_ok;
  assign dreq.dividend = {acc_merge, 3'b000};
  assign dreq.divisor  = chan[1] ? {bits, 1'b0} : {1'b0, bits};

  wav_div u_div (
    .clk(clk), .rst(rst), .req(dreq), .busy(div_busy), .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      div_wait <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (acc && emit) begin
        div_wait <= 1'b1;
        pend_status <= emit_status;
      end else if (div_wait && !div_busy) begin
        div_wait <= 1'b0;
        out_valid <= 1'b1;
      end
    end
  end

  always_comb begin
    out_data = '0;
    out_data.status = pend_status;
    if (pend_status == ST_OK) begin
      out_data.riff_size = riff_size;
      out_data.metadata_length = meta;
      out_data.format_chunk_size = csize;
      out_data.channels = chan;
      out_data.rate_hz = rate;
      out_data.bytes_per_sec = brate;
      out_data.block_align = align;
      out_data.sample_bits = bits;
      out_data.extra_length = $signed({1'b0, extra}) - 11'sd3;
      out_data.payload_bytes = dsize;
      out_data.block_count = quotient;
    end
  end

endmodule

// ===== hdl/wav_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WAV header parser port checker
// Watches the top level ports and flags handshake or result slips.
// ---------------------------------------------------------------------------
module wav_checker
  import wav_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_take_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_valid |-> in_stall)
    else $error("input taken while a result waits");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_SIZE_MISM)
    else $error("status out of range");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.riff_size == '0 &&
      out_data.block_count == '0)
    else $error("error result carries fields");

endmodule

bind wav_header_stream_parser wav_checker u_wav_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

// ===== tb/sv/wav_header_stream_parser_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// WAV header stream parser testbench
// Streams directed and randomized WAV headers, well-formed, corrupted,
// truncated and noisy, through the parser under random idling and stalls
// on both sides. Every result is checked field by field against a
// byte-level header predictor. The scan limit is changed between phases.
// ---------------------------------------------------------------------------
module wav_header_stream_parser_tb;
  import wav_pkg::*;

  typedef enum logic [4:0] {
    HP_RIFF, HP_RSIZE, HP_WAVE, HP_FMT, HP_SKIP, HP_CSIZE, HP_FORMAT, HP_CHAN,
    HP_RATE, HP_BRATE, HP_ALIGN, HP_BITS, HP_DSCAN, HP_DSIZE
  } hdr_phase_e;

  // Slots of the captured header fields.
  localparam int CAP_RIFF  = 0;
  localparam int CAP_META  = 1;
  localparam int CAP_CSIZE = 2;
  localparam int CAP_CHAN  = 3;
  localparam int CAP_RATE  = 4;
  localparam int CAP_BRATE = 5;
  localparam int CAP_ALIGN = 6;
  localparam int CAP_BITS  = 7;
  localparam int CAP_EXTRA = 8;
  localparam int CAP_DSIZE = 9;

  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 40;
  localparam int ItemsPerPass = 280;

  typedef struct {
    in_item_t   item;
    bit         chk;
    logic [2:0] status;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [9:0] cfg_data = '0;

  int errors = 0;
  bit quiet = 1'b0;
  bit force_restart = 1'b0;
  int pass_items;
  out_item_t expected_headers[$];
  in_item_t  hdr_bytes[$];

  // Predictor state.
  logic [9:0]  scan_lim;
  hdr_phase_e  ph;
  logic [9:0]  bcnt;
  logic [1:0]  mcnt;
  logic [31:0] win;
  logic [31:0] acc;
  logic [31:0] cap [10];

  always #5 clk = ~clk;

  wav_header_stream_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void parse_clear();
    ph = HP_RIFF;
    bcnt = '0;
    mcnt = '0;
    win = '0;
    acc = '0;
  endfunction

  function automatic bit take_field(input logic [7:0] b, input int n,
                                    output logic [31:0] v);
    acc |= 32'(b) << (8 * bcnt[1:0]);
    bcnt = bcnt + 10'd1;
    if (bcnt >= n) begin
      v = acc;
      acc = '0;
      bcnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit finish_header(input logic [2:0] st, output out_item_t r);
    logic [63:0] dv;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      dv = 64'(cap[CAP_CHAN]) * 64'(cap[CAP_BITS]);
      r.riff_size = cap[CAP_RIFF];
      r.metadata_length = cap[CAP_META][9:0];
      r.format_chunk_size = cap[CAP_CSIZE];
      r.channels = cap[CAP_CHAN][15:0];
      r.rate_hz = cap[CAP_RATE];
      r.bytes_per_sec = cap[CAP_BRATE];
      r.block_align = cap[CAP_ALIGN][15:0];
      r.sample_bits = cap[CAP_BITS][15:0];
      r.extra_length = 11'(cap[CAP_EXTRA] + 32'h800 - 32'd3);
      r.payload_bytes = cap[CAP_DSIZE];
      r.block_count = (dv != 0) ? 35'((64'(cap[CAP_DSIZE]) * 64'd8) / dv) : 35'd0;
    end
    parse_clear();
    return 1'b1;
  endfunction

  // Advances the predicted parser by one byte; returns 1 when a result is due.
  function automatic bit predict_header_byte(input in_item_t it, output out_item_t r);
    logic [7:0]  b;
    logic [31:0] v;
    logic [7:0]  fmt_tag [3];
    int          cnt;
    bit          done;
    b = it.data_byte;
    fmt_tag = '{FMT_F, FMT_M, FMT_T};
    r = '0;
    if (it.restart) parse_clear();
    case (ph)
      HP_RIFF, HP_WAVE: begin
        win = {win[23:0], b};
        bcnt = bcnt + 10'd1;
        if (bcnt >= 4) begin
          bcnt = '0;
          if (ph == HP_RIFF) begin
            if (win != TAG_RIFF) return finish_header(ST_NOT_RIFF, r);
            ph = HP_RSIZE;
          end else begin
            if (win != TAG_WAVE) return finish_header(ST_NOT_WAVE, r);
            ph = HP_FMT;
            mcnt = '0;
          end
          win = '0;
        end
      end
      HP_RSIZE: if (take_field(b, 4, v)) begin
        cap[CAP_RIFF] = v;
        ph = HP_WAVE;
      end
      HP_FMT: begin
        cnt = int'(bcnt);
        done = 1'b0;
        if (cnt >= scan_lim) begin
          done = 1'b1;
        end else begin
          cnt++;
          if (b == fmt_tag[mcnt % 3]) mcnt = mcnt + 2'd1;
          else mcnt = '0;
          if (mcnt >= 3) done = 1'b1;
        end
        if (done) begin
          cap[CAP_META] = (cnt > 3) ? cnt - 3 : 0;
          bcnt = '0;
          mcnt = '0;
          ph = HP_SKIP;
        end else begin
          bcnt = 10'(cnt);
        end
      end
      HP_SKIP: ph = HP_CSIZE;
      HP_CSIZE: if (take_field(b, 4, v)) begin
        cap[CAP_CSIZE] = v;
        ph = HP_FORMAT;
      end
      HP_FORMAT: if (take_field(b, 2, v)) begin
        if (v != 1) return finish_header(ST_NOT_PCM, r);
        ph = HP_CHAN;
      end
      HP_CHAN: if (take_field(b, 2, v)) begin
        if (v != 1 && v != 2) return finish_header(ST_BAD_CHAN, r);
        cap[CAP_CHAN] = v;
        ph = HP_RATE;
      end
      HP_RATE: if (take_field(b, 4, v)) begin
        cap[CAP_RATE] = v;
        ph = HP_BRATE;
      end
      HP_BRATE: if (take_field(b, 4, v)) begin
        cap[CAP_BRATE] = v;
        ph = HP_ALIGN;
      end
      HP_ALIGN: if (take_field(b, 2, v)) begin
        cap[CAP_ALIGN] = v;
        ph = HP_BITS;
      end
      HP_BITS: if (take_field(b, 2, v)) begin
        cap[CAP_BITS] = v;
        ph = HP_DSCAN;
        win = '0;
        mcnt = '0;
        bcnt = '0;
      end
      HP_DSCAN: begin
        // The first scan byte is not counted against the limit.
        if (mcnt != 0) bcnt = bcnt + 10'd1;
        mcnt = 2'd1;
        win = {win[23:0], b};
        if (win == TAG_DATA || bcnt >= scan_lim) begin
          cap[CAP_EXTRA] = 32'(bcnt);
          bcnt = '0;
          mcnt = '0;
          win = '0;
          acc = '0;
          ph = HP_DSIZE;
        end
      end
      HP_DSIZE: if (take_field(b, 4, v)) begin
        cap[CAP_DSIZE] = v;
        if (32'(cap[CAP_CHAN] * cap[CAP_BITS]) != 32'(cap[CAP_ALIGN] * 32'd8))
          return finish_header(ST_SIZE_MISM, r);
        return finish_header(ST_OK, r);
      end
      default: parse_clear();
    endcase
    return 1'b0;
  endfunction

  // Drives one item and returns at the edge that accepts it.
  task automatic send_item(input in_item_t it, output bit emitted, output out_item_t r);
    bit go;
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    emitted = predict_header_byte(it, r);
    if (emitted) expected_headers.push_back(r);
    pass_items++;
  endtask

  task automatic drain_and_set_limit(input logic [9:0] lim);
    bit go;
    in_valid <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    do begin
      @(negedge clk);
      go = cfg_ready;
      @(posedge clk);
    end while (!go);
    cfg_valid <= 1'b0;
    scan_lim = lim;
  endtask

  function automatic void push_byte(input logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.restart = 1'b0;
    hdr_bytes.push_back(it);
  endfunction

  function automatic void push_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) push_byte(v[8*i +: 8]);
  endfunction

  function automatic void push_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) push_byte(t[8*i +: 8]);
  endfunction

  // Builds one header, mostly well-formed, sometimes random noise, corrupted or cut short.
  function automatic void build_header();
    int mode;
    int n;
    int pos;
    logic [15:0] ch;
    logic [15:0] bits;
    logic [15:0] align;
    logic [31:0] dsize;
    mode = $urandom_range(99);
    hdr_bytes.delete();
    if (mode < 5) begin
      n = $urandom_range(1, 20);
      for (int i = 0; i < n; i++) push_byte(8'($urandom()));
      foreach (hdr_bytes[i]) hdr_bytes[i].restart = 1'($urandom_range(1));
      return;
    end
    push_tag(TAG_RIFF);
    push_le(($urandom_range(9) == 0) ? 32'hFFFF_FFFF : $urandom(), 4);
    push_tag(TAG_WAVE);
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) push_byte(8'($urandom()));
    push_byte(FMT_F);
    push_byte(FMT_M);
    push_byte(FMT_T);
    push_byte(8'($urandom()));
    push_le(($urandom_range(3) == 0) ? $urandom() : 32'd16, 4);
    push_le(32'd1, 2);
    ch = ($urandom_range(19) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 2));
    case ($urandom_range(5))
      0: bits = 16'd0;
      1: bits = 16'd8;
      2: bits = 16'd16;
      3: bits = 16'd24;
      4: bits = 16'd32;
      default: bits = 16'($urandom());
    endcase
    align = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'((ch * bits) / 8);
    push_le(32'(ch), 2);
    push_le($urandom(), 4);
    push_le($urandom(), 4);
    push_le(32'(align), 2);
    push_le(32'(bits), 2);
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) push_byte(8'($urandom()));
    push_tag(TAG_DATA);
    case ($urandom_range(9))
      0: dsize = 32'hFFFF_FFFF;
      1: dsize = 32'd0;
      default: dsize = $urandom();
    endcase
    push_le(dsize, 4);
    if (mode < 20) begin
      pos = $urandom_range(hdr_bytes.size() - 1);
      hdr_bytes[pos].data_byte ^= 8'($urandom_range(1, 255));
    end else if (mode < 30) begin
      n = $urandom_range(1, hdr_bytes.size() - 1);
      while (hdr_bytes.size() > n) void'(hdr_bytes.pop_back());
    end
    hdr_bytes[0].restart = force_restart | ($urandom_range(3) == 0);
    // A cut-short header leaves the parser mid-stream, so the next one restarts.
    force_restart = (mode >= 20 && mode < 30);
  endfunction

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.status != want.status)
      report_mismatch("status", 64'(got.status), 64'(want.status));
    if (got.riff_size != want.riff_size)
      report_mismatch("riff_size", 64'(got.riff_size), 64'(want.riff_size));
    if (got.metadata_length != want.metadata_length)
      report_mismatch("metadata_length", 64'(got.metadata_length),
                      64'(want.metadata_length));
    if (got.format_chunk_size != want.format_chunk_size)
      report_mismatch("format_chunk_size", 64'(got.format_chunk_size),
                      64'(want.format_chunk_size));
    if (got.channels != want.channels)
      report_mismatch("channels", 64'(got.channels), 64'(want.channels));
    if (got.rate_hz != want.rate_hz)
      report_mismatch("rate_hz", 64'(got.rate_hz), 64'(want.rate_hz));
    if (got.bytes_per_sec != want.bytes_per_sec)
      report_mismatch("bytes_per_sec", 64'(got.bytes_per_sec), 64'(want.bytes_per_sec));
    if (got.block_align != want.block_align)
      report_mismatch("block_align", 64'(got.block_align), 64'(want.block_align));
    if (got.sample_bits != want.sample_bits)
      report_mismatch("sample_bits", 64'(got.sample_bits), 64'(want.sample_bits));
    if (got.extra_length != want.extra_length)
      report_mismatch("extra_length", 64'(11'(got.extra_length)),
                      64'(11'(want.extra_length)));
    if (got.payload_bytes != want.payload_bytes)
      report_mismatch("payload_bytes", 64'(got.payload_bytes), 64'(want.payload_bytes));
    if (got.block_count != want.block_count)
      report_mismatch("block_count", 64'(got.block_count), 64'(want.block_count));
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 9);
  end

  // Result monitor: handshake and payload are sampled mid-cycle.
  always begin
    bit        take;
    out_item_t got;
    @(negedge clk);
    take = out_valid && !out_stall && !rst;
    got = out_data;
    @(posedge clk);
    if (take) begin
      if (expected_headers.size() == 0) begin
        report_mismatch("unexpected result, status", 64'(got.status), 64'd0);
      end else begin
        check_result(got, expected_headers.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always begin
    int  idle_cycles;
    bit  fired;
    idle_cycles = 0;
    forever begin
      @(negedge clk);
      fired = (in_valid && !in_stall) || (out_valid && !out_stall) ||
              (cfg_valid && cfg_ready);
      @(posedge clk);
      if (fired || rst) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no item accepted for %0d cycles", StallLimit);
        $display("** wav_header_stream_parser: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t    dir_tab [21];
    bit          emitted;
    out_item_t   r;
    logic [9:0]  limits [5];
    dir_tab = '{
      '{'{8'h52, 1'b0}, 1'b0, ST_OK}, '{'{8'h49, 1'b0}, 1'b0, ST_OK},
      '{'{8'h46, 1'b0}, 1'b0, ST_OK}, '{'{8'h58, 1'b0}, 1'b1, ST_NOT_RIFF},
      '{'{8'h52, 1'b0}, 1'b0, ST_OK}, '{'{8'h49, 1'b0}, 1'b0, ST_OK},
      '{'{8'h46, 1'b0}, 1'b0, ST_OK}, '{'{8'h46, 1'b0}, 1'b0, ST_OK},
      '{'{8'hFF, 1'b0}, 1'b0, ST_OK}, '{'{8'hFF, 1'b0}, 1'b0, ST_OK},
      '{'{8'hFF, 1'b0}, 1'b0, ST_OK}, '{'{8'hFF, 1'b0}, 1'b0, ST_OK},
      '{'{8'h57, 1'b0}, 1'b0, ST_OK}, '{'{8'h41, 1'b0}, 1'b0, ST_OK},
      '{'{8'h56, 1'b0}, 1'b0, ST_OK}, '{'{8'h46, 1'b0}, 1'b1, ST_NOT_WAVE},
      '{'{8'h00, 1'b0}, 1'b0, ST_OK}, '{'{8'h52, 1'b1}, 1'b0, ST_OK},
      '{'{8'h49, 1'b0}, 1'b0, ST_OK}, '{'{8'h46, 1'b0}, 1'b0, ST_OK},
      '{'{8'h00, 1'b0}, 1'b1, ST_NOT_RIFF}
    };
    limits = '{10'd300, 10'd4, 10'd1023, 10'($urandom_range(4, 1023)), 10'd16};
    scan_lim = 10'd300;
    foreach (cap[i]) cap[i] = '0;
    parse_clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].item, emitted, r);
      if (dir_tab[i].chk && (!emitted || r.status != dir_tab[i].status))
        report_mismatch("directed status", emitted ? 64'(r.status) : 64'd7,
                        64'(dir_tab[i].status));
    end

    // The reset value is exercised first, then each written setting.
    foreach (limits[p]) begin
      if (p != 0) drain_and_set_limit(limits[p]);
      quiet = (p == 2);
      pass_items = 0;
      force_restart = 1'b1;
      while (pass_items < ItemsPerPass) begin
        build_header();
        foreach (hdr_bytes[i]) send_item(hdr_bytes[i], emitted, r);
      end
    end

    in_valid <= 1'b0;
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("** wav_header_stream_parser: PASSED **");
    end else begin
      $display("** wav_header_stream_parser: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wav_pkg.sv
hdl/wav_div.sv
hdl/wav_header_stream_parser.sv
hdl/wav_checker.sv
tb/sv/wav_header_stream_parser_tb.sv
